FILE: rtl/ac_rms_dc_removed_unit_macros.svh
// ----------------------------------------------------------------------------
// ac_rms_dc_removed_unit_macros
// Assertion macros shared by the AC RMS unit.
// ----------------------------------------------------------------------------
`ifndef AC_RMS_DC_REMOVED_UNIT_MACROS_SVH
`define AC_RMS_DC_REMOVED_UNIT_MACROS_SVH

// same-cycle implication
`define ACR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ACR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg
// Widths, constants and status types of the AC RMS unit.
// ----------------------------------------------------------------------------
package acr_pkg;

    localparam int ACR_DATA_W      = 24;
    localparam int ACR_CNT_W       = 15;
    localparam int ACR_SUM_W       = 64;
    localparam int ACR_MEAN_W      = 48;
    localparam int ACR_REM_W       = 25;
    localparam int ACR_UNIT_W      = 27;
    localparam int ACR_ITER_W      = 6;
    localparam int ACR_MAX_SAMPLES = 16384;
    localparam int ACR_SAMPLE_BITS = 24;

    typedef struct packed {
        logic                 busy;
        logic                 dropped;
        logic [ACR_CNT_W-1:0] count;
    } acr_acc_stat_t;

    typedef struct packed {
        logic                  valid;
        logic [ACR_DATA_W-1:0] rms;
        logic [ACR_CNT_W-1:0]  count;
        logic                  overflow;
    } acr_result_t;

endpackage

FILE: rtl/acr_sub_unit.sv
// ----------------------------------------------------------------------------
// acr_sub_unit
// Shared subtract-and-compare unit for the divide and square root steps.
// ----------------------------------------------------------------------------
module acr_sub_unit #(
    parameter int W = acr_pkg::ACR_UNIT_W
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         ge
);
    logic borrow;

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign ge = ~borrow;

endmodule

FILE: rtl/acr_accum.sv
// ----------------------------------------------------------------------------
// acr_accum
// Offset removal, squaring and sum/count accumulation, one word per cycle.
// ----------------------------------------------------------------------------
`include "ac_rms_dc_removed_unit_macros.svh"

module acr_accum #(
    parameter int MAX_SAMPLES = acr_pkg::ACR_MAX_SAMPLES,
    parameter int SAMPLE_BITS = acr_pkg::ACR_SAMPLE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [acr_pkg::ACR_DATA_W-1:0]       cfg_wdata,
    input  logic                                 accept,
    input  logic [acr_pkg::ACR_DATA_W-1:0]       sample,
    input  logic                                 clear,
    output logic [acr_pkg::ACR_SUM_W-1:0]        sum,
    output acr_pkg::acr_acc_stat_t               stat
);
    import acr_pkg::*;

    localparam logic [ACR_CNT_W-1:0] MAX_CNT = ACR_CNT_W'(MAX_SAMPLES);

    logic [ACR_DATA_W-1:0]  dc_offset_reg;
    logic [ACR_DATA_W-1:0]  mag_reg;
    logic [ACR_DATA_W-1:0]  mag_next;
    logic                   mag_v_reg;
    logic [ACR_MEAN_W-1:0]  sq_reg;
    logic                   sq_v_reg;
    logic [ACR_SUM_W-1:0]   sum_reg;
    logic [ACR_CNT_W-1:0]   count_reg;
    logic                   dropped_reg;
    logic                   room;
    logic signed [ACR_DATA_W:0] s_ext;
    logic signed [ACR_DATA_W:0] d_ext;
    logic signed [ACR_DATA_W:0] diff;
    logic [ACR_DATA_W:0]    neg_diff;

    assign s_ext    = {{(ACR_DATA_W + 1 - SAMPLE_BITS){sample[SAMPLE_BITS-1]}},
                       sample[SAMPLE_BITS-1:0]};
    assign d_ext    = {dc_offset_reg[ACR_DATA_W-1], dc_offset_reg};
    assign diff     = s_ext - d_ext;
    assign neg_diff = -diff;
    assign mag_next = diff[ACR_DATA_W] ? neg_diff[ACR_DATA_W-1:0] : diff[ACR_DATA_W-1:0];
    assign room     = (count_reg < MAX_CNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_offset_reg <= '0;
            mag_v_reg     <= 1'b0;
            sq_v_reg      <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dc_offset_reg <= cfg_wdata;
            end
            mag_v_reg <= accept && room;
            sq_v_reg  <= mag_v_reg;
            if (clear)
            begin
                sum_reg     <= '0;
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
            else
            begin
                if (sq_v_reg)
                begin
                    sum_reg <= sum_reg + ACR_SUM_W'(sq_reg);
                end
                if (accept && room)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (accept && !room)
                begin
                    dropped_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg <= mag_next;
        end
        if (mag_v_reg)
        begin
            sq_reg <= mag_reg * mag_reg;
        end
    end

    assign sum          = sum_reg;
    assign stat.busy    = mag_v_reg | sq_v_reg;
    assign stat.dropped = dropped_reg;
    assign stat.count   = count_reg;

    `ACR_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= MAX_CNT, "count above limit")
    `ACR_ASSERT_NEXT(a_drop_full, accept && !clear && count_reg == MAX_CNT,
        !mag_v_reg && dropped_reg, "word accumulated past limit")
    `ACR_ASSERT_NOW(a_clear_idle, clear, !accept && !mag_v_reg && !sq_v_reg,
        "clear while pipeline busy")

endmodule

FILE: rtl/acr_seq.sv
// ----------------------------------------------------------------------------
// acr_seq
// Sequencer: long division of the sum by the count, then digit-by-digit
// square root, both on the shared subtract unit.
// ----------------------------------------------------------------------------
`include "ac_rms_dc_removed_unit_macros.svh"

module acr_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [acr_pkg::ACR_SUM_W-1:0]  sum,
    input  acr_pkg::acr_acc_stat_t         acc,
    input  logic                           res_ready,
    output logic                           idle,
    output logic                           clear,
    output acr_pkg::acr_result_t           res
);
    import acr_pkg::*;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_DRAIN,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [ACR_ITER_W-1:0]  iter_reg;
    logic [ACR_SUM_W-1:0]   dvd_reg;
    logic [ACR_CNT_W-1:0]   divisor_reg;
    logic [ACR_CNT_W-1:0]   rem_div_reg;
    logic                   ovf_reg;
    logic [ACR_MEAN_W-1:0]  rad_reg;
    logic [ACR_REM_W-1:0]   rem_sq_reg;
    logic [ACR_DATA_W-1:0]  root_reg;

    logic [ACR_UNIT_W-1:0]  op_a;
    logic [ACR_UNIT_W-1:0]  op_b;
    logic [ACR_UNIT_W-1:0]  op_diff;
    logic                   op_ge;
    logic [ACR_CNT_W:0]     div_sh;
    logic [ACR_UNIT_W-1:0]  sq_sh;

    assign div_sh = {rem_div_reg, dvd_reg[ACR_SUM_W-1]};
    assign sq_sh  = {rem_sq_reg, rad_reg[ACR_MEAN_W-1 -: 2]};

    always_comb
    begin
        case (state_reg)
            ST_SQRT:
            begin
                op_a = sq_sh;
                op_b = ACR_UNIT_W'({root_reg, 2'b01});
            end
            default:
            begin
                op_a = ACR_UNIT_W'(div_sh);
                op_b = ACR_UNIT_W'(divisor_reg);
            end
        endcase
    end

    acr_sub_unit #(
        .W (ACR_UNIT_W)
    ) u_sub (
        .a    (op_a),
        .b    (op_b),
        .diff (op_diff),
        .ge   (op_ge)
    );

    assign idle         = (state_reg == ST_ACC);
    assign clear        = (state_reg == ST_DRAIN) && !acc.busy;
    assign res.valid    = (state_reg == ST_DONE) && res_ready;
    assign res.rms      = root_reg;
    assign res.count    = divisor_reg;
    assign res.overflow = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            iter_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_ACC:
                begin
                    if (start)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!acc.busy)
                    begin
                        state_reg <= ST_DIV;
                        iter_reg  <= ACR_ITER_W'(ACR_SUM_W - 1);
                    end
                end
                ST_DIV:
                begin
                    iter_reg <= iter_reg - 1'b1;
                    if (iter_reg == '0)
                    begin
                        state_reg <= ST_SQRT;
                        iter_reg  <= ACR_ITER_W'(ACR_DATA_W - 1);
                    end
                end
                ST_SQRT:
                begin
                    iter_reg <= iter_reg - 1'b1;
                    if (iter_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_ACC;
                    end
                end
                default:
                begin
                    state_reg <= ST_ACC;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_DRAIN:
            begin
                dvd_reg     <= sum;
                divisor_reg <= acc.count;
                ovf_reg     <= acc.dropped;
                rem_div_reg <= '0;
            end
            ST_DIV:
            begin
                dvd_reg     <= {dvd_reg[ACR_SUM_W-2:0], op_ge};
                rem_div_reg <= op_ge ? op_diff[ACR_CNT_W-1:0] : div_sh[ACR_CNT_W-1:0];
                if (iter_reg == '0)
                begin
                    // empty period reads as zero mean
                    rad_reg    <= (divisor_reg == '0) ? '0
                                : {dvd_reg[ACR_MEAN_W-2:0], op_ge};
                    rem_sq_reg <= '0;
                    root_reg   <= '0;
                end
            end
            ST_SQRT:
            begin
                rad_reg    <= {rad_reg[ACR_MEAN_W-3:0], 2'b00};
                rem_sq_reg <= op_ge ? op_diff[ACR_REM_W-1:0] : sq_sh[ACR_REM_W-1:0];
                root_reg   <= {root_reg[ACR_DATA_W-2:0], op_ge};
            end
            default:
            begin
            end
        endcase
    end

    `ACR_ASSERT_NOW(a_start_idle, start, state_reg == ST_ACC, "start while busy")
    `ACR_ASSERT_NEXT(a_div_to_sqrt, state_reg == ST_DIV && iter_reg == '0,
        state_reg == ST_SQRT, "divide did not hand over to root")
    `ACR_ASSERT_NEXT(a_res_back, res.valid, state_reg == ST_ACC && !clear,
        "sequencer did not return after result")

endmodule

FILE: rtl/ac_rms_dc_removed_unit.sv
// ----------------------------------------------------------------------------
// ac_rms_dc_removed_unit
// AC RMS of one measurement period with DC offset removal.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata carries one signed ADC sample per word, s_axis_tlast
// marks the last sample of the period. Words are taken one per cycle while the
// unit accumulates; the offset-removed square is summed through a 3-stage
// subtract/square/add pipeline.
// The word with tlast starts the result: the pipeline drains, a 64-step
// restoring divide of the sum by the count runs, then a 24-step root, both on
// one shared subtract unit, and the result is handed to the output register.
// s_axis_tready is low from the tlast word until the result has entered the
// output register.
// Output stream: one word per period with rms, count and the overflow flag.
// The output register holds a word until taken; samples of the next period are
// accepted meanwhile, and its result waits until the register is free.
// cfg_we/cfg_wdata write the DC offset; write only while idle.
// Reset clears sums, count, flag, offset and all valid state.
// ----------------------------------------------------------------------------
module ac_rms_dc_removed_unit #(
    parameter int MAX_SAMPLES = acr_pkg::ACR_MAX_SAMPLES,
    parameter int SAMPLE_BITS = acr_pkg::ACR_SAMPLE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,      // dc_offset
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // sample
    input  logic        s_axis_tlast,   // last_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // rms [23:0], sample_count [38:24], zero
    output logic        m_axis_tuser    // overflow
);
    import acr_pkg::*;

    logic                   s_accept;
    logic                   start;
    logic                   clear;
    logic                   idle;
    logic                   res_ready;
    logic [ACR_SUM_W-1:0]   sum;
    acr_acc_stat_t          acc_stat;
    acr_result_t            res;

    logic                   m_valid_reg;
    logic [ACR_DATA_W-1:0]  rms_reg;
    logic [ACR_CNT_W-1:0]   count_reg;
    logic                   ovf_reg;

    assign s_axis_tready = idle;
    assign s_accept      = s_axis_tvalid && idle;
    assign start         = s_accept && s_axis_tlast;
    assign res_ready     = !m_valid_reg || m_axis_tready;

    acr_accum #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (s_accept),
        .sample    (s_axis_tdata),
        .clear     (clear),
        .sum       (sum),
        .stat      (acc_stat)
    );

    acr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .sum       (sum),
        .acc       (acc_stat),
        .res_ready (res_ready),
        .idle      (idle),
        .clear     (clear),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            rms_reg   <= res.rms;
            count_reg <= res.count;
            ovf_reg   <= res.overflow;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, count_reg, rms_reg};
    assign m_axis_tuser  = ovf_reg;

endmodule
